>>> rtl/core/elastic_collision_2d_unit_assert.svh
// ----------------------------------------------------------------------------
// elastic collision unit assertion macros
// Shared concurrent assertion forms for the collision unit checkers.
// ----------------------------------------------------------------------------
`ifndef ELASTIC_COLLISION_2D_UNIT_ASSERT_SVH
`define ELASTIC_COLLISION_2D_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ECU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("collision unit assertion failed");

// consequent must hold in the cycle after the antecedent
`define ECU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("collision unit assertion failed");

`endif

>>> rtl/core/ecu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_pkg
// Types, widths and status codes shared by the collision unit modules.
// ----------------------------------------------------------------------------
package ecu_pkg;

   // fraction bits of the unit normal and mass factors
   localparam int DIR_BITS = 28;

   localparam int VAL_W   = 32;
   localparam int DELTA_W = VAL_W + 1;
   localparam int NORM_W  = DIR_BITS;
   localparam int SQ_W    = 2 * NORM_W + 1;
   localparam int ROOT_W  = NORM_W + 1;
   localparam int QUO_W   = DIR_BITS + 1;
   localparam int UNIT_W  = QUO_W + 1;
   localparam int MSUM_W  = VAL_W + 1;
   localparam int LEAD_W  = 6;
   localparam int SHAMT_W = 5;
   localparam int PD_W    = DELTA_W + UNIT_W;
   localparam int DOT_W   = PD_W + 1;
   localparam int SPD_W   = 35;
   localparam int KP_W    = UNIT_W + SPD_W;
   localparam int IMP_W   = 36;
   localparam int JP_W    = IMP_W + UNIT_W;
   localparam int CORR_W  = JP_W - DIR_BITS;
   localparam int RES_W   = CORR_W + 1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ZERO_MASS = 2'd1;
   localparam logic [1:0] ST_COINCIDE  = 2'd2;

   // one input transaction
   typedef struct packed {
      logic [VAL_W-1:0] mass_b;
      logic [VAL_W-1:0] mass_a;
      logic [VAL_W-1:0] vel_b_y;
      logic [VAL_W-1:0] vel_b_x;
      logic [VAL_W-1:0] vel_a_y;
      logic [VAL_W-1:0] vel_a_x;
      logic [VAL_W-1:0] pos_b_y;
      logic [VAL_W-1:0] pos_b_x;
      logic [VAL_W-1:0] pos_a_y;
      logic [VAL_W-1:0] pos_a_x;
   } in_type;

   // classified item held between front and back
   typedef struct packed {
      logic [1:0]         status;
      logic [DELTA_W-1:0] dx;
      logic [DELTA_W-1:0] dy;
      logic [VAL_W-1:0]   va_x;
      logic [VAL_W-1:0]   va_y;
      logic [VAL_W-1:0]   vb_x;
      logic [VAL_W-1:0]   vb_y;
      logic [VAL_W-1:0]   mass_a;
      logic [VAL_W-1:0]   mass_b;
   } entry_type;

   // side data carried along the back pipeline
   typedef struct packed {
      logic [1:0]         status;
      logic               sx;
      logic               sy;
      logic [DELTA_W-1:0] dvx;
      logic [DELTA_W-1:0] dvy;
      logic [VAL_W-1:0]   va_x;
      logic [VAL_W-1:0]   va_y;
      logic [VAL_W-1:0]   vb_x;
      logic [VAL_W-1:0]   vb_y;
      logic [VAL_W-1:0]   mass_a;
      logic [VAL_W-1:0]   mass_b;
      logic [NORM_W-1:0]  axn;
      logic [NORM_W-1:0]  ayn;
   } pay_type;

   // one result transaction
   typedef struct packed {
      logic [1:0]       status;
      logic [VAL_W-1:0] new_vel_b_y;
      logic [VAL_W-1:0] new_vel_b_x;
      logic [VAL_W-1:0] new_vel_a_y;
      logic [VAL_W-1:0] new_vel_a_x;
   } res_type;

endpackage

>>> rtl/core/ecu_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_sqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module ecu_sqrt #(
   parameter int ROOT_W = 29
) (
   input  logic                clock,
   input  logic                en_i,
   input  logic [2*ROOT_W-1:0] value_i,
   output logic [ROOT_W-1:0]   root_o
);
   localparam int V_W   = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic [V_W-1:0]    val_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [V_W-1:0]    val_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;

      if (s == 0) begin : g_first
         assign val_cur  = value_i;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign val_cur  = val_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
      end

      // bring down two bits and try the next root bit
      assign rem_sh = {rem_cur[REM_W-3:0], val_cur[V_W-1 -: 2]};
      assign trial  = {root_cur, 2'b01};

      always_ff @(posedge clock) begin
         if (en_i) begin
            if (rem_sh >= trial) begin
               rem_ff[s]  <= rem_sh - trial;
               root_ff[s] <= {root_cur[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[s]  <= rem_sh;
               root_ff[s] <= {root_cur[ROOT_W-2:0], 1'b0};
            end
            val_ff[s] <= {val_cur[V_W-3:0], 2'b00};
         end
      end
   end

   assign root_o = root_ff[ROOT_W-1];

endmodule

>>> rtl/core/ecu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_div
// Pipelined restoring divider, one quotient bit per stage. The quotient
// must fit in Q_W bits (numerator below divisor times two to the Q_W).
// ----------------------------------------------------------------------------
module ecu_div #(
   parameter int DEN_W = 29,
   parameter int Q_W   = 29
) (
   input  logic                 clock,
   input  logic                 en_i,
   input  logic [Q_W+DEN_W-1:0] num_i,
   input  logic [DEN_W-1:0]     den_i,
   output logic [Q_W-1:0]       quo_o
);
   localparam int NUM_W = Q_W + DEN_W;

   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [Q_W-1:0]   low_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      logic [DEN_W-1:0] rem_cur;
      logic [Q_W-1:0]   low_cur;
      logic [DEN_W-1:0] den_cur;
      logic [DEN_W:0]   rem_sh;
      logic [DEN_W:0]   rem_sub;

      if (s == 0) begin : g_first
         assign rem_cur = num_i[NUM_W-1 -: DEN_W];
         assign low_cur = num_i[Q_W-1:0];
         assign den_cur = den_i;
      end else begin : g_next
         assign rem_cur = rem_ff[s-1];
         assign low_cur = low_ff[s-1];
         assign den_cur = den_ff[s-1];
      end

      // shift in the next numerator bit, subtract when it fits
      assign rem_sh  = {rem_cur, low_cur[Q_W-1]};
      assign rem_sub = rem_sh - {1'b0, den_cur};

      always_ff @(posedge clock) begin
         if (en_i) begin
            if (rem_sh >= {1'b0, den_cur}) begin
               rem_ff[s] <= rem_sub[DEN_W-1:0];
               low_ff[s] <= {low_cur[Q_W-2:0], 1'b1};
            end else begin
               rem_ff[s] <= rem_sh[DEN_W-1:0];
               low_ff[s] <= {low_cur[Q_W-2:0], 1'b0};
            end
            den_ff[s] <= den_cur;
         end
      end
   end

   assign quo_o = low_ff[Q_W-1];

endmodule

>>> rtl/core/ecu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_front
// Accepts collision transactions, classifies them and queues them.
// ----------------------------------------------------------------------------
module ecu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid_i,
   output logic               in_ready_o,
   input  ecu_pkg::in_type    in_item_i,
   output logic               q_valid_o,
   input  logic               q_pop_i,
   output ecu_pkg::entry_type q_entry_o
);
   import ecu_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   entry_type        fifo_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   entry_type        entry;
   logic             push;
   logic             pop;

   // classify: zero mass first, then coinciding centres
   always_comb begin
      entry.dx = {in_item_i.pos_b_x[VAL_W-1], in_item_i.pos_b_x}
               - {in_item_i.pos_a_x[VAL_W-1], in_item_i.pos_a_x};
      entry.dy = {in_item_i.pos_b_y[VAL_W-1], in_item_i.pos_b_y}
               - {in_item_i.pos_a_y[VAL_W-1], in_item_i.pos_a_y};
      entry.va_x   = in_item_i.vel_a_x;
      entry.va_y   = in_item_i.vel_a_y;
      entry.vb_x   = in_item_i.vel_b_x;
      entry.vb_y   = in_item_i.vel_b_y;
      entry.mass_a = in_item_i.mass_a;
      entry.mass_b = in_item_i.mass_b;
      priority if (in_item_i.mass_a == '0 || in_item_i.mass_b == '0) begin
         entry.status = ST_ZERO_MASS;
      end else if (in_item_i.pos_a_x == in_item_i.pos_b_x &&
                   in_item_i.pos_a_y == in_item_i.pos_b_y) begin
         entry.status = ST_COINCIDE;
      end else begin
         entry.status = ST_OK;
      end
   end

   // queue control
   assign in_ready_o = (cnt_ff != CNT_W'(DEPTH));
   assign push       = in_valid_i & in_ready_o;
   assign q_valid_o  = (cnt_ff != '0);
   assign pop        = q_pop_i & q_valid_o;
   assign q_entry_o  = fifo_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ff] <= entry;
      end
   end

endmodule

>>> rtl/core/ecu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_back
// Collision datapath: normalize, square root, unit normal and mass factor
// divisions, normal speed exchange and saturation, then the output register.
// ----------------------------------------------------------------------------
module ecu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid_i,
   output logic               q_pop_o,
   input  ecu_pkg::entry_type q_entry_i,
   output logic               rsp_valid_o,
   input  logic               rsp_ready_i,
   output ecu_pkg::res_type   rsp_data_o
);
   import ecu_pkg::*;

   localparam int NSTG = 4 + ROOT_W + QUO_W + 6;

   localparam logic [DOT_W-1:0] DOT_HALF =
      {{(DOT_W-DIR_BITS){1'b0}}, 1'b1, {(DIR_BITS-1){1'b0}}};
   localparam logic [KP_W-1:0] KP_HALF =
      {{(KP_W-DIR_BITS){1'b0}}, 1'b1, {(DIR_BITS-1){1'b0}}};
   localparam logic [JP_W-1:0] JP_HALF =
      {{(JP_W-DIR_BITS){1'b0}}, 1'b1, {(DIR_BITS-1){1'b0}}};

   function automatic logic [VAL_W-1:0] sat_val(input logic [RES_W-1:0] v);
      logic [VAL_W-1:0] r;
      if (v[RES_W-1:VAL_W-1] == '0 || v[RES_W-1:VAL_W-1] == '1) begin
         r = v[VAL_W-1:0];
      end else if (v[RES_W-1]) begin
         r = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(VAL_W-1){1'b1}}};
      end
      return r;
   endfunction

   logic            adv;
   logic [NSTG-1:0] vld_ff;
   logic            out_vld_ff;
   res_type         out_ff;

   // stage 0: magnitudes and normalizing shift amount
   logic [DELTA_W-1:0] abs_x, abs_y, mx;
   logic [LEAD_W-1:0]  lead;
   logic               rsh;
   logic [SHAMT_W-1:0] amt;
   pay_type            pay0;
   logic [DELTA_W-1:0] ax_ff, ay_ff;
   logic               rsh_ff;
   logic [SHAMT_W-1:0] amt_ff;
   pay_type            pay0_ff;

   // stages 1 to 3: shift, squares, sum
   pay_type           pay1_ff, pay2_ff, pay3_ff;
   pay_type           pay1;
   logic [NORM_W-1:0] axn, ayn;
   logic [2*NORM_W-1:0] sqx_ff, sqy_ff;
   logic [SQ_W-1:0]   sum_ff;

   // square root and divider alignment
   logic [ROOT_W-1:0] root;
   pay_type           pay_sq_ff [ROOT_W];
   pay_type           pay_dv_ff [QUO_W];
   pay_type           pdv;
   logic [QUO_W-1:0]  uxm, uym, kbq, kaq;

   // normal speed exchange stages
   pay_type                   pay_m_ff [6];
   logic signed [UNIT_W-1:0]  ux_ff [5];
   logic signed [UNIT_W-1:0]  uy_ff [5];
   logic [QUO_W-1:0]          kb_ff [3];
   logic [QUO_W-1:0]          ka_ff [3];
   logic signed [DELTA_W-1:0] m1_dvx, m1_dvy;
   logic signed [PD_W-1:0]    pdx_ff, pdy_ff;
   logic [DOT_W-1:0]          dot_r;
   logic signed [SPD_W-1:0]   s_ff;
   logic signed [KP_W-1:0]    kp1_ff, kp2_ff;
   logic [KP_W-1:0]           kp1_r, kp2_r;
   logic signed [IMP_W-1:0]   j1_ff, j2_ff;
   logic signed [JP_W-1:0]    jax_ff, jay_ff, jbx_ff, jby_ff;
   logic [JP_W-1:0]           jax_r, jay_r, jbx_r, jby_r;
   logic [RES_W-1:0]          rax, ray, rbx, rby;
   res_type                   res;

   // whole pipeline moves when the output register can take a result
   assign adv     = ~out_vld_ff | rsp_ready_i;
   assign q_pop_o = adv & q_valid_i;

   always_comb begin
      abs_x = q_entry_i.dx[DELTA_W-1] ? (~q_entry_i.dx + 1'b1) : q_entry_i.dx;
      abs_y = q_entry_i.dy[DELTA_W-1] ? (~q_entry_i.dy + 1'b1) : q_entry_i.dy;
      mx    = (abs_x > abs_y) ? abs_x : abs_y;
      lead  = '0;
      for (int i = 0; i < DELTA_W; i++) begin
         if (mx[i]) begin
            lead = LEAD_W'(i);
         end
      end
      if (lead >= LEAD_W'(NORM_W - 1)) begin
         rsh = 1'b1;
         amt = SHAMT_W'(lead - LEAD_W'(NORM_W - 1));
      end else begin
         rsh = 1'b0;
         amt = SHAMT_W'(LEAD_W'(NORM_W - 1) - lead);
      end
      pay0.status = q_entry_i.status;
      pay0.sx     = q_entry_i.dx[DELTA_W-1];
      pay0.sy     = q_entry_i.dy[DELTA_W-1];
      pay0.dvx    = {q_entry_i.vb_x[VAL_W-1], q_entry_i.vb_x}
                  - {q_entry_i.va_x[VAL_W-1], q_entry_i.va_x};
      pay0.dvy    = {q_entry_i.vb_y[VAL_W-1], q_entry_i.vb_y}
                  - {q_entry_i.va_y[VAL_W-1], q_entry_i.va_y};
      pay0.va_x   = q_entry_i.va_x;
      pay0.va_y   = q_entry_i.va_y;
      pay0.vb_x   = q_entry_i.vb_x;
      pay0.vb_y   = q_entry_i.vb_y;
      pay0.mass_a = q_entry_i.mass_a;
      pay0.mass_b = q_entry_i.mass_b;
      pay0.axn    = '0;
      pay0.ayn    = '0;
   end

   // normalize so the larger magnitude has its top bit at NORM_W-1
   always_comb begin
      if (rsh_ff) begin
         axn = NORM_W'(ax_ff >> amt_ff);
         ayn = NORM_W'(ay_ff >> amt_ff);
      end else begin
         axn = NORM_W'(ax_ff << amt_ff);
         ayn = NORM_W'(ay_ff << amt_ff);
      end
      pay1     = pay0_ff;
      pay1.axn = axn;
      pay1.ayn = ayn;
   end

   ecu_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
      .clock   (clock),
      .en_i    (adv),
      .value_i ({{(2*ROOT_W-SQ_W){1'b0}}, sum_ff}),
      .root_o  (root)
   );

   // unit normal magnitudes and mass factors
   assign pdv = pay_sq_ff[ROOT_W-1];

   ecu_div #(.DEN_W(ROOT_W), .Q_W(QUO_W)) u_div_ux (
      .clock (clock),
      .en_i  (adv),
      .num_i ((QUO_W+ROOT_W)'({pdv.axn, {DIR_BITS{1'b0}}})),
      .den_i (root),
      .quo_o (uxm)
   );

   ecu_div #(.DEN_W(ROOT_W), .Q_W(QUO_W)) u_div_uy (
      .clock (clock),
      .en_i  (adv),
      .num_i ((QUO_W+ROOT_W)'({pdv.ayn, {DIR_BITS{1'b0}}})),
      .den_i (root),
      .quo_o (uym)
   );

   ecu_div #(.DEN_W(MSUM_W), .Q_W(QUO_W)) u_div_kb (
      .clock (clock),
      .en_i  (adv),
      .num_i ((QUO_W+MSUM_W)'({pdv.mass_b, {(DIR_BITS+1){1'b0}}})),
      .den_i (MSUM_W'(pdv.mass_a) + MSUM_W'(pdv.mass_b)),
      .quo_o (kbq)
   );

   ecu_div #(.DEN_W(MSUM_W), .Q_W(QUO_W)) u_div_ka (
      .clock (clock),
      .en_i  (adv),
      .num_i ((QUO_W+MSUM_W)'({pdv.mass_a, {(DIR_BITS+1){1'b0}}})),
      .den_i (MSUM_W'(pdv.mass_a) + MSUM_W'(pdv.mass_b)),
      .quo_o (kaq)
   );

   // rounding of the products, half toward plus infinity
   assign m1_dvx = pay_m_ff[0].dvx;
   assign m1_dvy = pay_m_ff[0].dvy;
   assign dot_r  = {pdx_ff[PD_W-1], pdx_ff} + {pdy_ff[PD_W-1], pdy_ff} + DOT_HALF;
   assign kp1_r  = kp1_ff + KP_HALF;
   assign kp2_r  = kp2_ff + KP_HALF;
   assign jax_r  = jax_ff + JP_HALF;
   assign jay_r  = jay_ff + JP_HALF;
   assign jbx_r  = jbx_ff + JP_HALF;
   assign jby_r  = jby_ff + JP_HALF;

   // new velocities with saturation, pass-through on a special case
   always_comb begin
      rax = {{(RES_W-VAL_W){pay_m_ff[5].va_x[VAL_W-1]}}, pay_m_ff[5].va_x}
          + {jax_r[JP_W-1], jax_r[DIR_BITS +: CORR_W]};
      ray = {{(RES_W-VAL_W){pay_m_ff[5].va_y[VAL_W-1]}}, pay_m_ff[5].va_y}
          + {jay_r[JP_W-1], jay_r[DIR_BITS +: CORR_W]};
      rbx = {{(RES_W-VAL_W){pay_m_ff[5].vb_x[VAL_W-1]}}, pay_m_ff[5].vb_x}
          - {jbx_r[JP_W-1], jbx_r[DIR_BITS +: CORR_W]};
      rby = {{(RES_W-VAL_W){pay_m_ff[5].vb_y[VAL_W-1]}}, pay_m_ff[5].vb_y}
          - {jby_r[JP_W-1], jby_r[DIR_BITS +: CORR_W]};
      res.status = pay_m_ff[5].status;
      if (pay_m_ff[5].status == ST_OK) begin
         res.new_vel_a_x = sat_val(rax);
         res.new_vel_a_y = sat_val(ray);
         res.new_vel_b_x = sat_val(rbx);
         res.new_vel_b_y = sat_val(rby);
      end else begin
         res.new_vel_a_x = pay_m_ff[5].va_x;
         res.new_vel_a_y = pay_m_ff[5].va_y;
         res.new_vel_b_x = pay_m_ff[5].vb_x;
         res.new_vel_b_y = pay_m_ff[5].vb_y;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff   <= abs_x;
         ay_ff   <= abs_y;
         rsh_ff  <= rsh;
         amt_ff  <= amt;
         pay0_ff <= pay0;

         pay1_ff <= pay1;

         sqx_ff  <= (2*NORM_W)'(pay1_ff.axn) * (2*NORM_W)'(pay1_ff.axn);
         sqy_ff  <= (2*NORM_W)'(pay1_ff.ayn) * (2*NORM_W)'(pay1_ff.ayn);
         pay2_ff <= pay1_ff;

         sum_ff  <= SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
         pay3_ff <= pay2_ff;

         pay_sq_ff[0] <= pay3_ff;
         for (int i = 1; i < ROOT_W; i++) begin
            pay_sq_ff[i] <= pay_sq_ff[i-1];
         end
         pay_dv_ff[0] <= pdv;
         for (int i = 1; i < QUO_W; i++) begin
            pay_dv_ff[i] <= pay_dv_ff[i-1];
         end

         // signed unit normal
         ux_ff[0] <= pay_dv_ff[QUO_W-1].sx ? -$signed({1'b0, uxm}) : $signed({1'b0, uxm});
         uy_ff[0] <= pay_dv_ff[QUO_W-1].sy ? -$signed({1'b0, uym}) : $signed({1'b0, uym});
         kb_ff[0] <= kbq;
         ka_ff[0] <= kaq;
         pay_m_ff[0] <= pay_dv_ff[QUO_W-1];
         for (int i = 1; i < 5; i++) begin
            ux_ff[i] <= ux_ff[i-1];
            uy_ff[i] <= uy_ff[i-1];
         end
         for (int i = 1; i < 3; i++) begin
            kb_ff[i] <= kb_ff[i-1];
            ka_ff[i] <= ka_ff[i-1];
         end
         for (int i = 1; i < 6; i++) begin
            pay_m_ff[i] <= pay_m_ff[i-1];
         end

         // relative normal speed
         pdx_ff <= m1_dvx * ux_ff[0];
         pdy_ff <= m1_dvy * uy_ff[0];
         s_ff   <= $signed(dot_r[DIR_BITS +: SPD_W]);

         // impulse terms
         kp1_ff <= $signed({1'b0, kb_ff[2]}) * s_ff;
         kp2_ff <= $signed({1'b0, ka_ff[2]}) * s_ff;
         j1_ff  <= $signed(kp1_r[DIR_BITS +: IMP_W]);
         j2_ff  <= $signed(kp2_r[DIR_BITS +: IMP_W]);

         // velocity corrections along the normal
         jax_ff <= j1_ff * ux_ff[4];
         jay_ff <= j1_ff * uy_ff[4];
         jbx_ff <= j2_ff * ux_ff[4];
         jby_ff <= j2_ff * uy_ff[4];

         out_ff <= res;
      end
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[NSTG-2:0], q_valid_i};
         out_vld_ff <= vld_ff[NSTG-1];
      end
   end

   assign rsp_valid_o = out_vld_ff;
   assign rsp_data_o  = out_ff;

endmodule

>>> rtl/core/elastic_collision_2d_unit.sv
`timescale 1ns / 1ps
// throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined root and dividers
// a 4-entry queue between classifier and datapath absorbs input while output stalls
// reset clears the queue pointers and all stage valid flags; datapath is not reset
// ----------------------------------------------------------------------------
// elastic_collision_2d_unit
// Two-disc elastic collision: mass-weighted exchange of the normal velocity components of a pair.
// ----------------------------------------------------------------------------
module elastic_collision_2d_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y,
   // mass_a, mass_b (32 bits each, from bit 0 up)
   input  logic [319:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y (32 bits each)
   output logic [127:0] rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser
);
   import ecu_pkg::*;

   in_type    in_item;
   entry_type q_entry;
   logic      q_valid;
   logic      q_pop;
   res_type   rsp_data;

   // unpack the input transaction
   assign in_item = {req_tdata[319:288], req_tdata[287:256], req_tdata[255:224],
                     req_tdata[223:192], req_tdata[191:160], req_tdata[159:128],
                     req_tdata[127:96],  req_tdata[95:64],   req_tdata[63:32],
                     req_tdata[31:0]};

   ecu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid_i (req_tvalid),
      .in_ready_o (req_tready),
      .in_item_i  (in_item),
      .q_valid_o  (q_valid),
      .q_pop_i    (q_pop),
      .q_entry_o  (q_entry)
   );

   ecu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid_i   (q_valid),
      .q_pop_o     (q_pop),
      .q_entry_i   (q_entry),
      .rsp_valid_o (rsp_tvalid),
      .rsp_ready_i (rsp_tready),
      .rsp_data_o  (rsp_data)
   );

   // pack the result transaction
   assign rsp_tdata = {rsp_data.new_vel_b_y, rsp_data.new_vel_b_x,
                       rsp_data.new_vel_a_y, rsp_data.new_vel_a_x};
   assign rsp_tuser = rsp_data.status;

endmodule

>>> rtl/core/ecu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecu_checker
// Port-level checks of the collision unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "elastic_collision_2d_unit_assert.svh"

module ecu_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // a stalled result holds
   `ECU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a result goes away only after it was taken
   `ECU_ASSERT_SAME(a_rsp_drop, clock, reset, $fell(rsp_tvalid) && !$past(reset), $past(rsp_tready))

   // queue can only fill up behind an output stall
   `ECU_ASSERT_SAME(a_full_stall, clock, reset, !req_tready && !$past(reset), $past(rsp_tvalid && !rsp_tready))

   // reset empties the block
   `ECU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready)

endmodule

bind elastic_collision_2d_unit ecu_checker u_checker (.*);
